// ===== rtl/core/coo_sparse_matrix_vector_multiply_defines.svh =====
// Assertion macros for the checker of the sparse matrix-vector block.
`ifndef COO_SPARSE_MATRIX_VECTOR_MULTIPLY_DEFINES_SVH
`define COO_SPARSE_MATRIX_VECTOR_MULTIPLY_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define COO_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define COO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/coo_spmv_pkg.sv =====
// Package with the types, codes and constants of the sparse matrix-vector block.
`timescale 1ns / 1ps
package coo_spmv_pkg;

    // Default storage sizes.
    localparam int MAX_ROWS_DEF   = 32;
    localparam int VECTOR_LEN_DEF = 256;

    // Fixed port widths.
    localparam int MODE_W     = 2;
    localparam int ROW_PORT_W = 5;
    localparam int COL_W      = 8;
    localparam int VAL_W      = 32;
    localparam int SUM_W      = 64;
    localparam int CFG_W      = 6;

    localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(32);

    // Item codes carried on the mode field.
    localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ELEM    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DRAIN   = 2'd2;
    // The remaining code is accepted and has no effect.
    localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_READ,
        ST_LOAD
    } t_drn_state;

    // Control from the drain sequencer to the accumulator datapath.
    typedef struct packed {
        logic rd_en;
        logic clear;
    } t_drn_ctl;

endpackage

// ===== rtl/core/coo_spmv_ram.sv =====
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps
module coo_spmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/coo_spmv_mac.sv =====
// Element pipeline: multiply, accumulator read-modify-write with forwarding, row valid bits.
`timescale 1ns / 1ps
module coo_spmv_mac import coo_spmv_pkg::*; #(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [ROW_W-1:0]        i_row,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic signed [VAL_W-1:0] i_vec_rdata,
    output logic [ROW_W-1:0]        o_acc_raddr,
    input  logic [SUM_W-1:0]        i_acc_rdata,
    output logic                    o_acc_we,
    output logic [ROW_W-1:0]        o_acc_waddr,
    output logic [SUM_W-1:0]        o_acc_wdata,
    input  logic                    i_clear,
    output logic [MAX_ROWS-1:0]     o_row_vld,
    output logic                    o_busy
);

    logic                    r_s1_vld;
    logic [ROW_W-1:0]        r_s1_row;
    logic signed [VAL_W-1:0] r_s1_val;
    logic                    r_s2_vld;
    logic [ROW_W-1:0]        r_s2_row;
    logic signed [SUM_W-1:0] r_s2_prod;
    logic                    r_wb_vld;
    logic [ROW_W-1:0]        r_wb_row;
    logic [SUM_W-1:0]        r_wb_data;
    logic [MAX_ROWS-1:0]     r_row_vld;
    logic [MAX_ROWS-1:0]     n_row_vld;
    logic signed [SUM_W-1:0] prod;
    logic [SUM_W-1:0]        acc_base;
    logic [SUM_W-1:0]        acc_sum;

    assign prod = r_s1_val * i_vec_rdata;

    // The memory read for the stage two row was issued while the previous
    // write was still in flight, so that write is forwarded. A row without
    // its valid bit has not been written since the last clear.
    always_comb begin
        if (r_wb_vld && (r_wb_row == r_s2_row)) begin
            acc_base = r_wb_data;
        end else if (r_row_vld[r_s2_row]) begin
            acc_base = i_acc_rdata;
        end else begin
            acc_base = '0;
        end
        acc_sum = acc_base + r_s2_prod;
    end

    always_comb begin
        n_row_vld = r_row_vld;
        if (i_clear) begin
            n_row_vld = '0;
        end
        if (r_s2_vld) begin
            n_row_vld[r_s2_row] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_wb_vld  <= 1'b0;
            r_row_vld <= '0;
        end else begin
            r_s1_vld  <= i_start;
            r_s2_vld  <= r_s1_vld;
            r_wb_vld  <= r_s2_vld;
            r_row_vld <= n_row_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_row  <= i_row;
        r_s1_val  <= i_value;
        r_s2_row  <= r_s1_row;
        r_s2_prod <= prod;
        r_wb_row  <= r_s2_row;
        r_wb_data <= acc_sum;
    end

    assign o_acc_raddr = r_s1_row;
    assign o_acc_we    = r_s2_vld;
    assign o_acc_waddr = r_s2_row;
    assign o_acc_wdata = acc_sum;
    assign o_row_vld   = r_row_vld;
    assign o_busy      = r_s1_vld | r_s2_vld;

endmodule

// ===== rtl/core/coo_spmv_drain.sv =====
// Drain sequencer: walks the accumulators in row order into the output register.
`timescale 1ns / 1ps
module coo_spmv_drain import coo_spmv_pkg::*; #(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int CNT_W = $clog2(MAX_ROWS + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [CNT_W-1:0]         i_eff_rows,
    input  logic                     i_mac_busy,
    input  logic [SUM_W-1:0]         i_acc_rdata,
    input  logic [MAX_ROWS-1:0]      i_row_vld,
    output t_drn_ctl                 o_ctl,
    output logic [ROW_W-1:0]         o_acc_raddr,
    output logic                     o_idle,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [ROW_PORT_W-1:0]    o_out_row,
    output logic signed [SUM_W-1:0]  o_row_sum,
    output logic                     o_last
);

    t_drn_state              r_state;
    t_drn_state              n_state;
    logic [ROW_W-1:0]        r_row;
    logic [ROW_W-1:0]        n_row;
    logic                    r_out_vld;
    logic [ROW_PORT_W-1:0]   r_out_row;
    logic [SUM_W-1:0]        r_out_sum;
    logic                    r_out_last;
    logic                    load;
    logic                    last_row;

    assign last_row = ((CNT_W'(r_row) + CNT_W'(1)) == i_eff_rows);

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        o_ctl   = '0;
        load    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                // Let elements already in the pipeline land first.
                if (!i_mac_busy) begin
                    if (i_eff_rows == '0) begin
                        o_ctl.clear = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        n_row   = '0;
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                // Issue the read only when the output register will be free.
                if (!r_out_vld || i_out_ready) begin
                    o_ctl.rd_en = 1'b1;
                    n_state     = ST_LOAD;
                end
            end
            ST_LOAD: begin
                load = 1'b1;
                if (last_row) begin
                    o_ctl.clear = 1'b1;
                    n_state     = ST_IDLE;
                end else begin
                    n_row   = r_row + ROW_W'(1);
                    n_state = ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_row     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            if (load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_row  <= ROW_PORT_W'(r_row);
            r_out_sum  <= i_row_vld[r_row] ? i_acc_rdata : '0;
            r_out_last <= last_row;
        end
    end

    assign o_acc_raddr = r_row;
    assign o_idle      = (r_state == ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_row   = r_out_row;
    assign o_row_sum   = r_out_sum;
    assign o_last      = r_out_last;

endmodule

// ===== rtl/core/coo_sparse_matrix_vector_multiply.sv =====
// Top level of the coordinate-format sparse matrix times dense vector block.
`timescale 1ns / 1ps
//
//  Channel  Direction  Handshake                  Payload
//  -------  ---------  -------------------------  ------------------------------
//  in       input      i_in_valid / o_in_ready    i_mode i_row i_col i_value
//  out      output     o_out_valid / i_out_ready  o_out_row o_row_sum o_last
//  cfg      input      i_cfg_we (no wait)         i_cfg_wdata (rows_in_use)
//
//  Loads and elements may follow back to back. An element's vector entry is read at its
//  acceptance edge and its accumulator is written once the product is registered;
//  a write still in flight is forwarded to the next read of the same row.
//  A drain waits for the element pipeline to empty, then reads and loads each row in turn,
//  held by output stalls; input ready stays low until the final row is loaded.
//  Reset is synchronous; per-row valid bits clear the accumulators without a clearing pass.
//
module coo_sparse_matrix_vector_multiply import coo_spmv_pkg::*; #(
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int VECTOR_LEN = VECTOR_LEN_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_W-1:0]        i_cfg_wdata,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [MODE_W-1:0]       i_mode,
    input  logic [ROW_PORT_W-1:0]   i_row,
    input  logic [COL_W-1:0]        i_col,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [ROW_PORT_W-1:0]   o_out_row,
    output logic signed [SUM_W-1:0] o_row_sum,
    output logic                    o_last
);

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W  = $clog2(MAX_ROWS + 1);
    localparam int VIDX_W = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;

    logic [CFG_W-1:0]        r_rows_in_use;
    logic [CNT_W-1:0]        eff_rows;
    logic                    in_acc;
    logic                    load_go;
    logic                    elem_go;
    logic                    drain_go;
    logic                    col_ok;
    logic [VIDX_W-1:0]       vec_idx;
    logic [VAL_W-1:0]        vec_rdata;
    logic [ROW_W-1:0]        mac_raddr;
    logic [ROW_W-1:0]        drn_raddr;
    logic [ROW_W-1:0]        acc_raddr;
    logic [SUM_W-1:0]        acc_rdata;
    logic                    acc_we;
    logic [ROW_W-1:0]        acc_waddr;
    logic [SUM_W-1:0]        acc_wdata;
    logic [MAX_ROWS-1:0]     row_vld;
    logic                    mac_busy;
    logic                    drn_idle;
    t_drn_ctl                drn_ctl;

    // The row count register; a value above the number of rows held saturates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= ROWS_RESET;
        end else if (i_cfg_we) begin
            r_rows_in_use <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (int'(r_rows_in_use) > MAX_ROWS) begin
            eff_rows = CNT_W'(MAX_ROWS);
        end else begin
            eff_rows = CNT_W'(r_rows_in_use);
        end
    end

    // Transactions are taken only while no drain is in progress. Elements with a zero value,
    // a row outside the rows in use or a column past the vector are dropped here, as is
    // the unused mode code.
    assign o_in_ready = drn_idle;
    assign in_acc     = i_in_valid && o_in_ready;
    assign col_ok     = (int'(i_col) < VECTOR_LEN);
    assign load_go    = in_acc && (i_mode == MODE_LOAD) && col_ok;
    assign elem_go    = in_acc && (i_mode == MODE_ELEM) && (i_value != '0) && col_ok
                        && (int'(i_row) < int'(eff_rows));
    assign drain_go   = in_acc && (i_mode == MODE_DRAIN);
    assign vec_idx    = VIDX_W'(i_col);

    // Dense vector store. The element's entry is read at the acceptance edge, so its data
    // meets the element in the first pipeline stage.
    coo_spmv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (VECTOR_LEN)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (load_go),
        .i_waddr (vec_idx),
        .i_wdata (i_value),
        .i_raddr (vec_idx),
        .o_rdata (vec_rdata)
    );

    // Row accumulators. The read port belongs to the drain sequencer while it reads and
    // to the element pipeline otherwise; the two never overlap.
    assign acc_raddr = drn_ctl.rd_en ? drn_raddr : mac_raddr;

    coo_spmv_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_ROWS)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (acc_waddr),
        .i_wdata (acc_wdata),
        .i_raddr (acc_raddr),
        .o_rdata (acc_rdata)
    );

    coo_spmv_mac #(
        .MAX_ROWS (MAX_ROWS)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (elem_go),
        .i_row       (ROW_W'(i_row)),
        .i_value     (i_value),
        .i_vec_rdata (vec_rdata),
        .o_acc_raddr (mac_raddr),
        .i_acc_rdata (acc_rdata),
        .o_acc_we    (acc_we),
        .o_acc_waddr (acc_waddr),
        .o_acc_wdata (acc_wdata),
        .i_clear     (drn_ctl.clear),
        .o_row_vld   (row_vld),
        .o_busy      (mac_busy)
    );

    coo_spmv_drain #(
        .MAX_ROWS (MAX_ROWS)
    ) u_drain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (drain_go),
        .i_eff_rows  (eff_rows),
        .i_mac_busy  (mac_busy),
        .i_acc_rdata (acc_rdata),
        .i_row_vld   (row_vld),
        .o_ctl       (drn_ctl),
        .o_acc_raddr (drn_raddr),
        .o_idle      (drn_idle),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_row   (o_out_row),
        .o_row_sum   (o_row_sum),
        .o_last      (o_last)
    );

endmodule

// ===== rtl/core/coo_spmv_checker.sv =====
// Port-level checker for the sparse matrix-vector block, bound to the top level.
`timescale 1ns / 1ps
`include "coo_sparse_matrix_vector_multiply_defines.svh"
module coo_spmv_checker import coo_spmv_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic [MODE_W-1:0]       i_mode,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic [ROW_PORT_W-1:0]   o_out_row,
    input logic signed [SUM_W-1:0] o_row_sum,
    input logic                    o_last
);

    logic [ROW_PORT_W-1:0] r_exp_row;
    logic                  out_acc;
    logic                  drain_acc;

    assign out_acc   = o_out_valid && i_out_ready;
    assign drain_acc = i_in_valid && o_in_ready && (i_mode == MODE_DRAIN);

    // Row expected next: restarts at zero after the final row of a drain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_row <= '0;
        end else if (out_acc) begin
            r_exp_row <= o_last ? '0 : (o_out_row + ROW_PORT_W'(1));
        end
    end

    `COO_ASSERT_NOW(a_row_order, i_clk, i_rst_n, o_out_valid, o_out_row == r_exp_row,
        "drain rows out of order")

    `COO_ASSERT_NEXT(a_drain_blocks, i_clk, i_rst_n, drain_acc, !o_in_ready,
        "input still ready after a drain was taken")

    `COO_ASSERT_NEXT(a_mid_drain_busy, i_clk, i_rst_n, out_acc && !o_last, !o_in_ready,
        "input ready before the final row was produced")

    `COO_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_row_sum) && $stable(o_out_row) && $stable(o_last),
        "stalled result changed or vanished")

endmodule

bind coo_sparse_matrix_vector_multiply coo_spmv_checker u_checker (.*);

// ===== verif/coo_sparse_matrix_vector_multiply_tb.sv =====
// Self-checking testbench for the coordinate-format sparse matrix times vector block.
`timescale 1ns / 1ps

module testbench;
    import coo_spmv_pkg::*;

    // Number of cycles allowed after the last expected row sum before the block is
    // considered idle. Element transactions reach their accumulator through the element
    // pipeline and produce no result, so this only needs to cover that pipeline.
    localparam int SETTLE_CYCLES = 20;
    // Generous limit on the whole run, in nanoseconds.
    localparam int RUN_LIMIT_NS  = 4_000_000;
    // Input transactions to send over the whole run, ignored ones included.
    localparam int TOTAL_ITEMS   = 380;

    // One expected drain result.
    typedef struct packed {
        logic [ROW_PORT_W-1:0] row;
        logic [SUM_W-1:0]      total;
        logic                  last;
    } t_row_sum;

    // Scoreboard: predicts the row sums from the accepted input transactions and checks
    // each output transaction against the oldest outstanding prediction.
    class row_sum_tracker;
        logic [VAL_W-1:0] vec_entry [VECTOR_LEN_DEF];
        logic [SUM_W-1:0] row_acc [MAX_ROWS_DEF];
        int unsigned      rows_held;
        t_row_sum         pending_sums [$];
        int unsigned      errors;

        function new();
            foreach (vec_entry[i]) vec_entry[i] = '0;
            foreach (row_acc[i]) row_acc[i] = '0;
            rows_held = MAX_ROWS_DEF;
            errors    = 0;
        endfunction

        // Register values above the row capacity saturate.
        function void set_rows(logic [CFG_W-1:0] v);
            rows_held = (v > MAX_ROWS_DEF) ? MAX_ROWS_DEF : v;
        endfunction

        function void note_transaction(logic [MODE_W-1:0] mode, logic [ROW_PORT_W-1:0] row,
                                       logic [COL_W-1:0] col, logic [VAL_W-1:0] value);
            logic [SUM_W-1:0] product;
            t_row_sum         r;
            case (mode)
                MODE_LOAD: begin
                    vec_entry[col] = value;
                end
                MODE_ELEM: begin
                    if (value != '0 && row < rows_held) begin
                        // The low 64 bits of the product of the sign-extended operands
                        // equal the wrapped signed product.
                        product = {{32{value[31]}}, value}
                                * {{32{vec_entry[col][31]}}, vec_entry[col]};
                        row_acc[row] = row_acc[row] + product;
                    end
                end
                MODE_DRAIN: begin
                    for (int i = 0; i < rows_held; i++) begin
                        r.row   = ROW_PORT_W'(i);
                        r.total = row_acc[i];
                        r.last  = (i + 1 == rows_held);
                        pending_sums.push_back(r);
                    end
                    foreach (row_acc[i]) row_acc[i] = '0;
                end
                default: ;
            endcase
        endfunction

        function void report(string what, logic signed [SUM_W-1:0] want,
                             logic signed [SUM_W-1:0] got);
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        endfunction

        function void check_sum(logic [ROW_PORT_W-1:0] row, logic [SUM_W-1:0] total,
                                logic last);
            t_row_sum want;
            if (pending_sums.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected row sum, expected none, actual row %0d sum %0d",
                         $time, row, $signed(total));
                return;
            end
            want = pending_sums.pop_front();
            if (row !== want.row) report("row index", want.row, row);
            if (total !== want.total) report("row sum", want.total, total);
            if (last !== want.last) report("last flag", want.last, last);
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_W-1:0]        i_cfg_wdata;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [MODE_W-1:0]       i_mode;
    logic [ROW_PORT_W-1:0]   i_row;
    logic [COL_W-1:0]        i_col;
    logic signed [VAL_W-1:0] i_value;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [ROW_PORT_W-1:0]   o_out_row;
    logic signed [SUM_W-1:0] o_row_sum;
    logic                    o_last;

    row_sum_tracker board;

    // Vector entries written so far. Elements only ever read these, since an entry that
    // has never been loaded holds no defined value.
    bit               vec_loaded [VECTOR_LEN_DEF];
    logic [COL_W-1:0] loaded_cols [$];

    // When a side is calm it neither idles nor stalls, which gives back-to-back stretches.
    bit in_calm  = 1'b0;
    bit out_calm = 1'b0;

    int unsigned sent_items = 0;

    always #4 i_clk = ~i_clk;

    coo_sparse_matrix_vector_multiply uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_row   (o_out_row),
        .o_row_sum   (o_row_sum),
        .o_last      (o_last)
    );

    // Drives one input transaction. Inputs change on the falling edge; acceptance is
    // sampled on the rising edge. Valid is lowered only when a gap is drawn, so it is
    // never lowered and raised again in the same time step.
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [ROW_PORT_W-1:0] row,
                             input logic [COL_W-1:0] col, input logic [VAL_W-1:0] value);
        int gap;
        if ($urandom_range(0, 15) == 0) in_calm = !in_calm;
        gap = in_calm ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_row      <= row;
        i_col      <= col;
        i_value    <= value;
        do @(posedge i_clk); while (!o_in_ready);
        sent_items++;
        board.note_transaction(mode, row, col, value);
        if (mode == MODE_LOAD && !vec_loaded[col]) begin
            vec_loaded[col] = 1'b1;
            loaded_cols.push_back(col);
        end
    endtask

    // Lets the block run dry: no input pending, every predicted sum received, and the
    // element pipeline given time to empty.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.pending_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Configuration write; only called while the block is idle.
    task automatic write_rows(input logic [CFG_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        board.set_rows(v);
    endtask

    // Operand values weighted towards the extremes.
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return '0;
            4:       return VAL_W'($urandom_range(0, 15));
            default: return $urandom();
        endcase
    endfunction

    // Random element on a column that has been loaded; the row is mostly one in use.
    task automatic send_element();
        logic [ROW_PORT_W-1:0] row;
        logic [COL_W-1:0]      col;
        logic [VAL_W-1:0]      value;
        col   = loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
        value = pick_value();
        if (board.rows_held > 0 && $urandom_range(0, 99) < 85)
            row = ROW_PORT_W'($urandom_range(0, board.rows_held - 1));
        else
            row = ROW_PORT_W'($urandom_range(0, 31));
        send_item(MODE_ELEM, row, col, value);
    endtask

    // Output side: draws a stall for each result, then takes and checks it.
    initial begin
        int gap;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
            gap = out_calm ? 0 : $urandom_range(0, 10);
            @(negedge i_clk);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            board.check_sum(o_out_row, o_row_sum, o_last);
        end
    end

    // Main stimulus: reset, a directed section covering the corner cases, then random
    // phases, each with its own row count and ending in a drain.
    initial begin
        int unsigned      phase;
        int unsigned      count;
        int unsigned      pick;
        logic [CFG_W-1:0] rows_setting;

        board       = new();
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_mode      = MODE_LOAD;
        i_row       = '0;
        i_col       = '0;
        i_value     = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extreme vector entries at the lowest and highest index.
        send_item(MODE_LOAD, 5'd0, 8'd0, 32'h7FFF_FFFF);
        send_item(MODE_LOAD, 5'd0, 8'd255, 32'h8000_0000);
        send_item(MODE_LOAD, 5'd0, 8'd1, 32'hFFFF_FFFF);
        send_item(MODE_LOAD, 5'd0, 8'd2, 32'd1);
        // Most negative times most positive, then most negative squared three times,
        // which wraps the last row's accumulator.
        send_item(MODE_ELEM, 5'd0, 8'd0, 32'h8000_0000);
        send_item(MODE_ELEM, 5'd31, 8'd255, 32'h8000_0000);
        send_item(MODE_ELEM, 5'd31, 8'd255, 32'h8000_0000);
        send_item(MODE_ELEM, 5'd31, 8'd255, 32'h8000_0000);
        send_item(MODE_ELEM, 5'd5, 8'd1, 32'h7FFF_FFFF);
        // A zero element value is skipped, and the unused mode is ignored outright.
        send_item(MODE_ELEM, 5'd3, 8'd2, 32'd0);
        send_item(MODE_IGNORED, 5'd31, 8'd255, 32'hFFFF_FFFF);
        send_item(MODE_DRAIN, 5'd0, 8'd0, 32'd0);
        settle();

        // A single row in use: elements on higher rows are ignored.
        write_rows(6'd1);
        send_item(MODE_ELEM, 5'd0, 8'd2, 32'd5);
        send_item(MODE_ELEM, 5'd1, 8'd2, 32'd7);
        send_item(MODE_DRAIN, 5'd0, 8'd0, 32'd0);
        settle();

        // No rows in use: the element is ignored and the drain produces nothing.
        write_rows(6'd0);
        send_item(MODE_ELEM, 5'd0, 8'd0, 32'd9);
        send_item(MODE_DRAIN, 5'd0, 8'd0, 32'd0);
        settle();

        // The largest register value saturates to the full row count.
        write_rows(6'd63);
        send_item(MODE_DRAIN, 5'd0, 8'd0, 32'd0);
        settle();

        // Random phases. Each is a well-formed sequence of loads and elements closed by
        // a drain, with the odd ignored transaction and an early drain mixed in.
        phase = 0;
        while (sent_items < TOTAL_ITEMS) begin
            case (phase % 6)
                0:       rows_setting = 6'd1;
                1:       rows_setting = 6'd63;
                2:       rows_setting = 6'd0;
                3:       rows_setting = 6'd32;
                default: rows_setting = CFG_W'($urandom_range(0, 63));
            endcase
            write_rows(rows_setting);
            count = $urandom_range(6, 30);
            for (int n = 0; n < count; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    send_item(MODE_LOAD, ROW_PORT_W'($urandom()), COL_W'($urandom()),
                              pick_value());
                end else if (pick < 88) begin
                    send_element();
                end else if (pick < 95) begin
                    send_item(MODE_IGNORED, ROW_PORT_W'($urandom()), COL_W'($urandom()),
                              $urandom());
                end else begin
                    send_item(MODE_DRAIN, ROW_PORT_W'($urandom()), COL_W'($urandom()),
                              $urandom());
                end
            end
            send_item(MODE_DRAIN, ROW_PORT_W'($urandom()), COL_W'($urandom()), $urandom());
            settle();
            phase++;
        end

        if (board.errors == 0 && board.pending_sums.size() == 0) begin
            $display("** coo_sparse_matrix_vector_multiply: PASSED **");
        end else begin
            $display("** coo_sparse_matrix_vector_multiply: FAILED **");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #(RUN_LIMIT_NS);
        $display("%0t ns: run time limit reached", $time);
        $display("** coo_sparse_matrix_vector_multiply: FAILED **");
        $finish;
    end

endmodule
